@@ design/dce_pkg.sv @@
// Shared types, constants and polymod helpers for the descriptor checksum engine.
`timescale 1ns / 1ps

package dce_pkg;

    localparam int ALPHA_LEN = 95;
    localparam int SUM_LEN   = 8;
    localparam int POLY_W    = 40;

    localparam logic [POLY_W-1:0] GEN0 = 40'hf5dee51989;
    localparam logic [POLY_W-1:0] GEN1 = 40'ha9fdca3312;
    localparam logic [POLY_W-1:0] GEN2 = 40'h1bab10e32d;
    localparam logic [POLY_W-1:0] GEN3 = 40'h3706b1677a;
    localparam logic [POLY_W-1:0] GEN4 = 40'h644d626ffd;

    // input alphabet, first character in the top byte
    localparam logic [8*ALPHA_LEN-1:0] IN_ALPHA = {
        "0123456789()[],'/*abcdefgh@:$%{}",
        "IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~",
        "ijklmnopqrstuvwxyzABCDEFGH`#\"\\ "
    };

    localparam logic [8*32-1:0] OUT_ALPHA = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    // one classified character
    typedef struct packed {
        logic       hit;    // character is in the alphabet
        logic [4:0] sym;    // position mod 32
        logic [1:0] grp;    // position / 32
        logic       last;
    } item_t;

    // state handed from the core to the finalize pipeline
    typedef struct packed {
        logic              bad;
        logic              flush;  // partial group pending
        logic [4:0]        acc;
        logic [POLY_W-1:0] poly;
    } fin_req_t;

    typedef struct packed {
        logic                        ok;
        logic [SUM_LEN-1:0][7:0]     chars;
        logic [POLY_W-1:0]           value;
    } result_t;

    function automatic logic [POLY_W-1:0] poly_fold(logic [POLY_W-1:0] s, logic [4:0] sym);
        logic [4:0]        top;
        logic [POLY_W-1:0] r;
        top = s[39:35];
        r   = {s[34:0], sym};
        if (top[0]) r = r ^ GEN0;
        if (top[1]) r = r ^ GEN1;
        if (top[2]) r = r ^ GEN2;
        if (top[3]) r = r ^ GEN3;
        if (top[4]) r = r ^ GEN4;
        return r;
    endfunction

    function automatic logic [POLY_W-1:0] poly_fold_zero3(logic [POLY_W-1:0] s);
        logic [POLY_W-1:0] r;
        r = poly_fold(s, 5'd0);
        r = poly_fold(r, 5'd0);
        r = poly_fold(r, 5'd0);
        return r;
    endfunction

    function automatic item_t classify(logic [7:0] code, logic last);
        item_t r;
        r.hit  = 1'b0;
        r.sym  = '0;
        r.grp  = '0;
        r.last = last;
        for (int i = 0; i < ALPHA_LEN; i++) begin
            if (IN_ALPHA[8*(ALPHA_LEN-1-i) +: 8] == code) begin
                r.hit = 1'b1;
                r.sym = 5'(i % 32);
                r.grp = 2'(i / 32);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] out_char(logic [4:0] idx);
        return OUT_ALPHA[8*(31 - int'(idx)) +: 8];
    endfunction

endpackage

@@ design/descriptor_checksum_engine.sv @@
// Top level of the descriptor checksum engine: front, queue, core and finalize pipeline.
`timescale 1ns / 1ps

//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------------------
//  s_axis  | in        | tdata[7:0] char_code, tlast is_last (final character)
//  m_axis  | out       | one beat per descriptor: ok, sum_char0..7, sum_value
//
//  Flow: one character per clock while nothing stalls; the core folds a character (and a closed
//  group) in the cycle it pops it from the queue. A result beat becomes valid once its last
//  character has passed the front register, the queue and the three finalize stages.
//  Reset: rst_n clears all valid flags, queue pointers and the core state (polymod = 1).
//  Stalls: the queue parts front from core; while a result waits on m_axis_tready the two
//  finalize stages behind the output register hold two more finished descriptors, after
//  which a last character holds the core and the queue fills.

module descriptor_checksum_engine
    import dce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  logic         s_axis_tlast,   // is_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata    // [0] ok, [8:1] sum_char0 .. [64:57] sum_char7,
                                         // [104:65] sum_value, [111:105] zero
);

    logic     front_valid, front_ready;
    item_t    front_item;
    logic     core_valid, core_ready;
    item_t    core_item;
    logic     fin_valid, fin_ready;
    fin_req_t fin_req;
    result_t  res;

    dce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_code   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    dce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    dce_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_valid),
        .in_ready  (core_ready),
        .in_item   (core_item),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_req   (fin_req)
    );

    dce_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fin_valid),
        .in_ready  (fin_ready),
        .in_req    (fin_req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // pack the result beat, ok in bit 0
    assign m_axis_tdata = {7'd0, res.value,
                           res.chars[7], res.chars[6], res.chars[5], res.chars[4],
                           res.chars[3], res.chars[2], res.chars[1], res.chars[0],
                           res.ok};

    // an errored descriptor reports all-zero checksum fields
    a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !res.ok) |-> (res.value == '0 && res.chars[0] == 8'd0))
        else $error("errored result carries checksum data");

    // a good result always shows a printable checksum character
    a_ok_char : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.ok) |-> (res.chars[0] != 8'd0 && res.chars[7] != 8'd0))
        else $error("good result with empty checksum character");

    // the core never hands a last character to the finalize pipeline while it is blocked
    a_last_pop : assert property (@(posedge clk) disable iff (!rst_n)
        (core_valid && core_ready && core_item.last) |-> fin_ready)
        else $error("last character popped while finalize stage is full");

endmodule

@@ design/dce_front.sv @@
// Front stage: registers incoming characters and classifies them against the alphabet.
`timescale 1ns / 1ps

module dce_front
    import dce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_code,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output item_t      out_item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= classify(in_code, in_last);
        end
    end

endmodule

@@ design/dce_queue.sv @@
// Short register queue between the front stage and the checksum core.
`timescale 1ns / 1ps

module dce_queue
    import dce_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != FULL_CNT;
    assign out_valid = count_reg != '0;
    assign out_item  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ design/dce_core.sv @@
// Checksum core: running polymod, base-3 group accumulator and sticky error flag.
`timescale 1ns / 1ps

module dce_core
    import dce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  item_t    in_item,
    output logic     fin_valid,
    input  logic     fin_ready,
    output fin_req_t fin_req
);

    logic [POLY_W-1:0] poly_reg, poly_next, poly_upd, poly_sym;
    logic [4:0]        acc_reg, acc_next, acc_upd, acc_sum;
    logic [1:0]        cnt_reg, cnt_next, cnt_upd, cnt_inc;
    logic              bad_reg, bad_next, bad_upd;
    logic              pop;

    // a last beat waits until the finalize pipeline can take it
    assign in_ready  = !in_item.last || fin_ready;
    assign fin_valid = in_valid && in_item.last;
    assign pop       = in_valid && in_ready;

    always_comb
    begin
        poly_sym = poly_fold(poly_reg, in_item.sym);
        acc_sum  = 5'({acc_reg, 1'b0} + {1'b0, acc_reg} + {4'd0, in_item.grp});
        cnt_inc  = cnt_reg + 2'd1;
        poly_upd = poly_reg;
        acc_upd  = acc_reg;
        cnt_upd  = cnt_reg;
        bad_upd  = bad_reg;
        if (!in_item.hit)
        begin
            bad_upd = 1'b1;
        end
        else if (cnt_inc == 2'd3)
        begin
            // third character closes the group
            poly_upd = poly_fold(poly_sym, acc_sum);
            acc_upd  = '0;
            cnt_upd  = '0;
        end
        else
        begin
            poly_upd = poly_sym;
            acc_upd  = acc_sum;
            cnt_upd  = cnt_inc;
        end

        fin_req.bad   = bad_upd;
        fin_req.flush = cnt_upd != 2'd0;
        fin_req.acc   = acc_upd;
        fin_req.poly  = poly_upd;

        poly_next = poly_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        bad_next  = bad_reg;
        if (pop)
        begin
            if (in_item.last)
            begin
                poly_next = 40'd1;
                acc_next  = '0;
                cnt_next  = '0;
                bad_next  = 1'b0;
            end
            else
            begin
                poly_next = poly_upd;
                acc_next  = acc_upd;
                cnt_next  = cnt_upd;
                bad_next  = bad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= 40'd1;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
        end
        else
        begin
            poly_reg <= poly_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            bad_reg  <= bad_next;
        end
    end

endmodule

@@ design/dce_final.sv @@
// Finalize pipeline: group flush, eight zero folds, xor with one, checksum characters.
`timescale 1ns / 1ps

module dce_final
    import dce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  fin_req_t in_req,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    logic              s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic              s1_ok_reg, s2_ok_reg;
    logic [POLY_W-1:0] s1_poly_reg, s2_poly_reg;
    result_t           out_res_reg;
    logic              ready1, ready2, ready3;
    logic [POLY_W-1:0] s1_poly_next, fin_poly;
    result_t           res_next;

    assign ready3    = !out_valid_reg || out_ready;
    assign ready2    = !s2_valid_reg || ready3;
    assign ready1    = !s1_valid_reg || ready2;
    assign in_ready  = ready1;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        s1_poly_next = in_req.flush ? poly_fold(in_req.poly, in_req.acc) : in_req.poly;
        s1_poly_next = poly_fold(s1_poly_next, 5'd0);
        s1_poly_next = poly_fold(s1_poly_next, 5'd0);

        fin_poly       = poly_fold_zero3(s2_poly_reg) ^ 40'd1;
        res_next.ok    = s2_ok_reg;
        res_next.value = s2_ok_reg ? fin_poly : '0;
        for (int j = 0; j < SUM_LEN; j++)
        begin
            res_next.chars[j] = s2_ok_reg ? out_char(fin_poly[5*(SUM_LEN-1-j) +: 5]) : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            s1_ok_reg   <= !in_req.bad;
            s1_poly_reg <= s1_poly_next;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_ok_reg   <= s1_ok_reg;
            s2_poly_reg <= poly_fold_zero3(s1_poly_reg);
        end
        if (ready3 && s2_valid_reg)
        begin
            out_res_reg <= res_next;
        end
    end

endmodule
